/* rtl/core/snh_pkg.sv */
// Package for the stereo noise gate with hold.
// Shared widths, register indexes and reset values; no dependencies.
`default_nettype none

package snh_pkg;

    // Default datapath sizes
    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int GAIN_FRAC_BITS_DEF = 16;

    // Fixed register and counter widths
    localparam int COEF_BITS     = 16;
    localparam int THRESH_BITS   = 23;
    localparam int HOLD_BITS     = 16;
    localparam int COUNT_BITS    = 16;
    localparam int CFG_DATA_BITS = 23;
    localparam int CFG_IDX_BITS  = 2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_CLS  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_OPN  = 2'd3;

    // Register reset values
    localparam logic [THRESH_BITS-1:0] THRESHOLD_RST = 23'd26527;
    localparam logic [HOLD_BITS-1:0]   HOLD_RST      = 16'd3840;
    localparam logic [COEF_BITS-1:0]   COEF_CLS_RST  = 16'd65506;
    localparam logic [COEF_BITS-1:0]   COEF_OPN_RST  = 16'd65506;

endpackage

`default_nettype wire

/* rtl/core/snh_mul.sv */
// Shared registered signed multiplier for the noise gate.
// Depends on snh_pkg for default operand widths.
`default_nettype none

module snh_mul #(
    parameter int A_BITS = snh_pkg::SAMPLE_BITS_DEF,
    parameter int B_BITS = snh_pkg::GAIN_FRAC_BITS_DEF + 2
) (
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic signed [A_BITS-1:0]   a,
    input  wire logic signed [B_BITS-1:0]   b,
    output logic signed [A_BITS+B_BITS-1:0] prod
);
    import snh_pkg::*;

    logic signed [A_BITS+B_BITS-1:0] prod_reg;

    // One product per enabled cycle, registered
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= (A_BITS+B_BITS)'(a) * (A_BITS+B_BITS)'(b);
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

/* rtl/core/stereo_noise_gate_hold.sv */
// Top level of the stereo noise gate with hold time.
// Depends on snh_pkg and snh_mul.
`default_nettype none

// Stereo noise gate. Each accepted request (one sample pair) is gated per
// channel: the magnitude is compared with threshold_level, run-length
// counters of samples above and below are kept, and once the matching
// count exceeds hold_samples the Q1.16 gain is smoothed toward open or
// closed with coef_open or coef_close. Outputs are sample * gain, floored.
// One multiplier is shared by four products per pair (two gain updates,
// two output scalings); for each channel the sequencer steps through EVAL,
// GAIN, MULS and OUT, and a new request is taken only once the previous
// pair has been loaded into the output register. A finished result sits
// in the output register while the next pair is processed. Configuration
// writes take effect at once and should be made while the block is idle.

module stereo_noise_gate_hold #(
    parameter int SAMPLE_BITS    = snh_pkg::SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = snh_pkg::GAIN_FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // input requests
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]     left_sample,
    input  wire logic signed [SAMPLE_BITS-1:0]     right_sample,
    input  wire logic                              block_last,
    // result requests
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [SAMPLE_BITS-1:0]          left_out,
    output logic signed [SAMPLE_BITS-1:0]          right_out,
    output logic                                   block_last_out,
    // configuration
    input  wire logic                              cfg_we,
    input  wire logic [snh_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [snh_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import snh_pkg::*;

    localparam int AW = (SAMPLE_BITS > COEF_BITS + 1) ? SAMPLE_BITS : COEF_BITS + 1;
    localparam int BW = GAIN_FRAC_BITS + 2;
    localparam int PW = AW + BW;
    localparam int GW = GAIN_FRAC_BITS + 1;
    localparam int MW = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;
    localparam int SW = GAIN_FRAC_BITS + COEF_BITS + 2;

    localparam logic [GW-1:0]        GAIN_UNITY = {1'b1, {GAIN_FRAC_BITS{1'b0}}};
    localparam logic [COEF_BITS:0]   COEF_ONE   = {1'b1, {COEF_BITS{1'b0}}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    // Sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EVAL = 3'd1;
    localparam logic [2:0] ST_GAIN = 3'd2;
    localparam logic [2:0] ST_MULS = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0] state_reg;
    logic       ch_reg;

    // Configuration registers
    logic [THRESH_BITS-1:0] thresh_reg;
    logic [HOLD_BITS-1:0]   hold_reg;
    logic [COEF_BITS-1:0]   coef_cls_reg;
    logic [COEF_BITS-1:0]   coef_opn_reg;

    // Channel state
    logic [GW-1:0]         gain_reg  [2];
    logic [COUNT_BITS-1:0] above_reg [2];
    logic [COUNT_BITS-1:0] below_reg [2];

    // Request payload and intermediate values
    logic signed [SAMPLE_BITS-1:0] samp_reg [2];
    logic                          last_reg;
    logic                          target_reg;
    logic                          move_reg;
    logic [COEF_BITS-1:0]          coef_reg;
    logic signed [SAMPLE_BITS-1:0] res_reg  [2];

    // Output register
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] left_out_reg;
    logic signed [SAMPLE_BITS-1:0] right_out_reg;
    logic                          last_out_reg;

    logic signed [SAMPLE_BITS-1:0] cur_s;
    logic [SAMPLE_BITS-1:0]        cur_u;
    logic [SAMPLE_BITS-1:0]        cur_mag;
    logic [GW-1:0]                 cur_gain;
    logic                          target;
    logic [COUNT_BITS-1:0]         above_inc;
    logic [COUNT_BITS-1:0]         below_inc;
    logic [COUNT_BITS-1:0]         count_next;
    logic                          move;
    logic [COEF_BITS-1:0]          coef_sel;
    logic [COEF_BITS:0]            coef_rem;
    logic [SW-1:0]                 addend;
    logic [SW-1:0]                 gain_sum;
    logic [GW-1:0]                 gain_next;

    logic                          mul_en;
    logic signed [AW-1:0]          mul_a;
    logic signed [BW-1:0]          mul_b;
    logic signed [PW-1:0]          mul_p;

    logic in_fire;
    logic out_load;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // Current channel: magnitude, target and counters
    assign cur_s      = samp_reg[ch_reg];
    assign cur_u      = cur_s;
    assign cur_mag    = cur_u[SAMPLE_BITS-1] ? (~cur_u + 1'b1) : cur_u;
    assign cur_gain   = gain_reg[ch_reg];
    assign target     = (MW'(cur_mag) >= MW'(thresh_reg));
    assign above_inc  = (above_reg[ch_reg] == COUNT_MAX) ? COUNT_MAX
                                                         : above_reg[ch_reg] + 1'b1;
    assign below_inc  = (below_reg[ch_reg] == COUNT_MAX) ? COUNT_MAX
                                                         : below_reg[ch_reg] + 1'b1;
    assign count_next = target ? above_inc : below_inc;
    assign move       = (count_next > hold_reg);
    // open coefficient only while target (unity) is above the gain
    assign coef_sel   = (target && (cur_gain != GAIN_UNITY)) ? coef_opn_reg : coef_cls_reg;

    // Smoother: (coef * gain + (1 - coef) * target) >> COEF_BITS
    assign coef_rem   = COEF_ONE - {1'b0, coef_reg};
    assign addend     = target_reg ? SW'({coef_rem, {GAIN_FRAC_BITS{1'b0}}}) : '0;
    assign gain_sum   = SW'(mul_p[GAIN_FRAC_BITS+COEF_BITS:0]) + addend;
    assign gain_next  = gain_sum[COEF_BITS +: GW];

    // Shared multiplier operand select
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = AW'(cur_s);
        mul_b  = $signed({1'b0, cur_gain});
        case (state_reg)
            ST_EVAL:
            begin
                mul_en = 1'b1;
                mul_a  = $signed({{(AW-COEF_BITS){1'b0}}, coef_sel});
            end
            ST_MULS:
            begin
                mul_en = 1'b1;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    snh_mul #(
        .A_BITS (AW),
        .B_BITS (BW)
    ) u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_p)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg   <= THRESHOLD_RST;
            hold_reg     <= HOLD_RST;
            coef_cls_reg <= COEF_CLS_RST;
            coef_opn_reg <= COEF_OPN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_THRESHOLD: thresh_reg   <= cfg_data[THRESH_BITS-1:0];
                CFG_HOLD:      hold_reg     <= cfg_data[HOLD_BITS-1:0];
                CFG_COEF_CLS:  coef_cls_reg <= cfg_data[COEF_BITS-1:0];
                CFG_COEF_OPN:  coef_opn_reg <= cfg_data[COEF_BITS-1:0];
                default:       thresh_reg   <= thresh_reg;
            endcase
        end
    end

    // Sequencer and channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ch_reg       <= 1'b0;
            gain_reg[0]  <= GAIN_UNITY;
            gain_reg[1]  <= GAIN_UNITY;
            above_reg[0] <= COUNT_ONE;
            above_reg[1] <= COUNT_ONE;
            below_reg[0] <= COUNT_ONE;
            below_reg[1] <= COUNT_ONE;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        ch_reg    <= 1'b0;
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL:
                begin
                    if (target)
                    begin
                        above_reg[ch_reg] <= above_inc;
                        below_reg[ch_reg] <= COUNT_ONE;
                    end
                    else
                    begin
                        below_reg[ch_reg] <= below_inc;
                        above_reg[ch_reg] <= COUNT_ONE;
                    end
                    state_reg <= ST_GAIN;
                end
                ST_GAIN:
                begin
                    if (move_reg)
                    begin
                        gain_reg[ch_reg] <= gain_next;
                    end
                    state_reg <= ST_MULS;
                end
                ST_MULS:
                begin
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    ch_reg    <= ~ch_reg;
                    state_reg <= ch_reg ? ST_DONE : ST_EVAL;
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload and intermediate registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            samp_reg[0] <= left_sample;
            samp_reg[1] <= right_sample;
            last_reg    <= block_last;
        end
        if (state_reg == ST_EVAL)
        begin
            target_reg <= target;
            move_reg   <= move;
            coef_reg   <= coef_sel;
        end
        if (state_reg == ST_OUT)
        begin
            // floor(product / 2^GAIN_FRAC_BITS), low sample bits
            res_reg[ch_reg] <= mul_p[GAIN_FRAC_BITS +: SAMPLE_BITS];
        end
        if (out_load)
        begin
            left_out_reg  <= res_reg[0];
            right_out_reg <= res_reg[1];
            last_out_reg  <= last_reg;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign left_out       = left_out_reg;
    assign right_out      = right_out_reg;
    assign block_last_out = last_out_reg;

endmodule

`default_nettype wire

/* rtl/core/snh_checker.sv */
// Port-level checker for the stereo noise gate, with its bind.
// Depends on snh_pkg for default widths.
`default_nettype none

module snh_port_checker #(
    parameter int SAMPLE_BITS = snh_pkg::SAMPLE_BITS_DEF
) (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_ready,
    input wire logic signed [SAMPLE_BITS-1:0]     left_sample,
    input wire logic signed [SAMPLE_BITS-1:0]     right_sample,
    input wire logic                              block_last,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic signed [SAMPLE_BITS-1:0]     left_out,
    input wire logic signed [SAMPLE_BITS-1:0]     right_out,
    input wire logic                              block_last_out,
    input wire logic                              cfg_we,
    input wire logic [snh_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input wire logic [snh_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import snh_pkg::*;

    // Input request holds until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(left_sample)
                                  && $stable(right_sample) && $stable(block_last))
        else $error("input request dropped or changed while stalled");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(left_out)
                                    && $stable(right_out) && $stable(block_last_out))
        else $error("result dropped or changed while stalled");

    // One pair at a time: busy after a request is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready while a pair is in progress");

    // A result needs several multiplier passes
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared too soon after a request");

endmodule

bind stereo_noise_gate_hold snh_port_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_snh_checker (.*);

`default_nettype wire

/* verif/snh_checker.sv */
// Result checker for the stereo noise gate with hold.
// Keeps its own copy of the gain, run-length and register state to predict
// each result, then compares it with the block's output. Depends on snh_pkg.

module snh_checker (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    input  wire logic                                 in_ready,
    input  wire logic [snh_pkg::SAMPLE_BITS_DEF-1:0]  left_sample,
    input  wire logic [snh_pkg::SAMPLE_BITS_DEF-1:0]  right_sample,
    input  wire logic                                 block_last,
    input  wire logic                                 out_valid,
    input  wire logic                                 out_ready,
    input  wire logic [snh_pkg::SAMPLE_BITS_DEF-1:0]  left_out,
    input  wire logic [snh_pkg::SAMPLE_BITS_DEF-1:0]  right_out,
    input  wire logic                                 block_last_out,
    input  wire logic                                 cfg_we,
    input  wire logic [snh_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  wire logic [snh_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output int                                        fail_count,
    output int                                        pending
);
    import snh_pkg::*;

    localparam int     SW          = SAMPLE_BITS_DEF;
    localparam int     FRAC        = GAIN_FRAC_BITS_DEF;
    localparam longint GAIN_UNITY  = longint'(1) << FRAC;
    localparam longint COEF_UNITY  = longint'(1) << COEF_BITS;
    localparam int     MAX_REPORTS = 10;

    typedef struct packed {
        logic [SW-1:0] left;
        logic [SW-1:0] right;
        logic          last;
    } gated_pair_t;

    // register copies
    logic [THRESH_BITS-1:0] thresh_q;
    logic [HOLD_BITS-1:0]   hold_q;
    logic [COEF_BITS-1:0]   coef_close_q;
    logic [COEF_BITS-1:0]   coef_open_q;

    // per channel gate state, index 0 is left
    logic [FRAC:0]          gain_q  [2];
    logic [COUNT_BITS-1:0]  above_q [2];
    logic [COUNT_BITS-1:0]  below_q [2];

    gated_pair_t            gated_q [$];
    gated_pair_t            want;

    // One channel step: update the run counts, smooth the gain once the
    // matching count is past the hold, then scale the sample (floored).
    function automatic logic [SW-1:0] gate_channel(input int ch, input logic [SW-1:0] smp);
        longint                s;
        longint                mag;
        longint                tq;
        longint                coef;
        longint                prod;
        logic                  loud;
        logic [COUNT_BITS-1:0] run;
        s    = longint'($signed(smp));
        mag  = (s < 0) ? -s : s;
        loud = (mag >= longint'(thresh_q));
        if (loud)
        begin
            above_q[ch] = (above_q[ch] == COUNT_MAX) ? COUNT_MAX : above_q[ch] + 1'b1;
            below_q[ch] = COUNT_BITS'(1);
            run         = above_q[ch];
        end
        else
        begin
            below_q[ch] = (below_q[ch] == COUNT_MAX) ? COUNT_MAX : below_q[ch] + 1'b1;
            above_q[ch] = COUNT_BITS'(1);
            run         = below_q[ch];
        end
        tq   = loud ? GAIN_UNITY : 0;
        // comparison uses the gain before this step's update
        coef = (tq <= longint'(gain_q[ch])) ? longint'(coef_close_q) : longint'(coef_open_q);
        if (run > hold_q)
            gain_q[ch] = (FRAC+1)'((coef * longint'(gain_q[ch]) + (COEF_UNITY - coef) * tq)
                                   >> COEF_BITS);
        prod = s * longint'(gain_q[ch]);
        return SW'(prod >>> FRAC);
    endfunction

    function automatic void note_failure(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("gate mismatch: %s", what);
    endfunction

    function automatic void compare_field(input string name, input logic [SW-1:0] exp_val,
                                          input logic [SW-1:0] got_val);
        if (got_val !== exp_val)
            note_failure($sformatf("%s expected %0d got %0d", name,
                                   $signed(exp_val), $signed(got_val)));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_q     = THRESHOLD_RST;
            hold_q       = HOLD_RST;
            coef_close_q = COEF_CLS_RST;
            coef_open_q  = COEF_OPN_RST;
            for (int ch = 0; ch < 2; ch++)
            begin
                gain_q[ch]  = (FRAC+1)'(GAIN_UNITY);
                above_q[ch] = COUNT_BITS'(1);
                below_q[ch] = COUNT_BITS'(1);
            end
            gated_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // register writes take effect at once
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_THRESHOLD: thresh_q     = cfg_data[THRESH_BITS-1:0];
                    CFG_HOLD:      hold_q       = cfg_data[HOLD_BITS-1:0];
                    CFG_COEF_CLS:  coef_close_q = cfg_data[COEF_BITS-1:0];
                    CFG_COEF_OPN:  coef_open_q  = cfg_data[COEF_BITS-1:0];
                    default: ;
                endcase
            end

            // accepted input request: predict its result
            if (in_valid && in_ready)
                gated_q.push_back('{left:  gate_channel(0, left_sample),
                                    right: gate_channel(1, right_sample),
                                    last:  block_last});

            // accepted result request: match against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (gated_q.size() == 0)
                    note_failure($sformatf("result with no request outstanding: %0d %0d",
                                           $signed(left_out), $signed(right_out)));
                else
                begin
                    want = gated_q.pop_front();
                    compare_field("left_out", want.left, left_out);
                    compare_field("right_out", want.right, right_out);
                    compare_field("block_last_out", SW'(want.last), SW'(block_last_out));
                end
            end
            pending = gated_q.size();
        end
    end

endmodule

/* verif/tb_top.sv */
// Testbench top for stereo_noise_gate_hold.
// Drives sample pair requests, result back-pressure and register writes, and
// gives the verdict. Depends on snh_pkg, snh_checker and the gate RTL.

module tb_top;
    import snh_pkg::*;

    localparam int          SW            = SAMPLE_BITS_DEF;
    localparam int          HOLD_OFF_LEN  = 300;
    localparam int          STALL_LIMIT   = 3000;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          RAND_PHASES   = 5;
    localparam int          PHASE_ITEMS   = 400;
    localparam int          SAT_ITEMS     = 40;
    localparam int unsigned FULL_SCALE    = 8388608;
    localparam int unsigned THRESH_MAX    = 8388607;
    localparam int unsigned REG16_MAX     = 65535;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [SW-1:0]            left_sample;
    logic [SW-1:0]            right_sample;
    logic                     block_last;
    logic                     out_valid;
    logic                     out_ready;
    logic [SW-1:0]            left_out;
    logic [SW-1:0]            right_out;
    logic                     block_last_out;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    int          fail_count;
    int          pending;
    int          stall_cycles = 0;
    bit          idle_on;
    int          hold_off_req;
    int          hold_off_seen;
    int unsigned cur_thresh;
    int unsigned cur_hold;
    int          run_left [2];
    bit          loud_now [2];

    stereo_noise_gate_hold i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .left_sample    (left_sample),
        .right_sample   (right_sample),
        .block_last     (block_last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .left_out       (left_out),
        .right_out      (right_out),
        .block_last_out (block_last_out),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    snh_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .left_sample    (left_sample),
        .right_sample   (right_sample),
        .block_last     (block_last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .left_out       (left_out),
        .right_out      (right_out),
        .block_last_out (block_last_out),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // watchdog: too long without any traffic ends the run
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: short random stalls, plus one long hold-off on request
    initial
    begin
        out_ready     = 1'b0;
        hold_off_seen = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req != hold_off_seen)
            begin
                hold_off_seen = hold_off_req;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_LEN - 1) @(negedge clk);
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Sample whose magnitude falls on the chosen side of the threshold.
    function automatic logic [SW-1:0] pick_level(input int unsigned thr, input bit loud);
        int unsigned m;
        int          s;
        if (loud || thr == 0)
            m = $urandom_range(FULL_SCALE, thr);
        else
            m = $urandom_range(thr - 1, 0);
        // sit right on the threshold edge now and then
        if ($urandom_range(0, 7) == 0)
            m = (loud || thr == 0) ? thr : thr - 1;
        // full-scale magnitude only exists as a negative sample
        s = (m == FULL_SCALE || $urandom_range(0, 1) == 1) ? -int'(m) : int'(m);
        return s[SW-1:0];
    endfunction

    // Runs of loud or quiet samples, sized around the hold, with some noise.
    function automatic logic [SW-1:0] next_sample(input int ch);
        int unsigned span;
        if ($urandom_range(0, 9) == 0)
            return SW'($urandom);
        if (run_left[ch] == 0)
        begin
            span         = (cur_hold > 30) ? 38 : cur_hold + 8;
            loud_now[ch] = ($urandom_range(0, 1) == 1);
            run_left[ch] = $urandom_range(1, span);
        end
        run_left[ch]--;
        return pick_level(cur_thresh, loud_now[ch]);
    endfunction

    task automatic send_pair(input logic [SW-1:0] l, input logic [SW-1:0] r, input logic last);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 3);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        left_sample  <= l;
        right_sample <= r;
        block_last   <= last;
        do @(posedge clk); while (!in_ready);
    endtask

    // stop sending and wait until every request has come back
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // bits above the register width carry junk, the block must ignore them
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int unsigned val,
                             input int bits);
        logic [CFG_DATA_BITS-1:0] keep;
        logic [CFG_DATA_BITS-1:0] junk;
        keep = (CFG_DATA_BITS'(1) << bits) - 1'b1;
        junk = CFG_DATA_BITS'($urandom);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= (CFG_DATA_BITS'(val) & keep) | (junk & ~keep);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic configure(input int unsigned thr, input int unsigned hold,
                             input int unsigned cls, input int unsigned opn);
        write_reg(CFG_THRESHOLD, thr, THRESH_BITS);
        write_reg(CFG_HOLD, hold, HOLD_BITS);
        write_reg(CFG_COEF_CLS, cls, COEF_BITS);
        write_reg(CFG_COEF_OPN, opn, COEF_BITS);
        cur_thresh = thr;
        cur_hold   = hold;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        left_sample  = '0;
        right_sample = '0;
        block_last   = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_THRESHOLD;
        cfg_data     = '0;
        idle_on      = 1'b0;
        hold_off_req = 0;
        cur_thresh   = THRESHOLD_RST;
        cur_hold     = HOLD_RST;
        run_left     = '{0, 0};
        loud_now     = '{1'b0, 1'b0};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: long hold, unity gain, samples pass unchanged
        send_pair(SW'(8388607), SW'(-8388608), 1'b0);
        send_pair(SW'(-8388608), SW'(8388607), 1'b1);
        send_pair(SW'(0), SW'(-1), 1'b0);
        send_pair(SW'(26527), SW'(-26527), 1'b1);
        send_pair(SW'(26526), SW'(-26528), 1'b0);
        send_pair(SW'(-26526), SW'(1), 1'b1);

        // zero hold and zero coefficients: gain snaps shut or fully open
        settle();
        configure(100000, 0, 0, 0);
        send_pair(SW'(50000), SW'(-50000), 1'b0);
        send_pair(SW'(8388607), SW'(-8388608), 1'b1);
        send_pair(SW'(-99999), SW'(99999), 1'b0);
        send_pair(SW'(100000), SW'(-100000), 1'b1);

        // hold of two, halving close, slowest open that never reaches unity
        settle();
        configure(100000, 2, 32768, REG16_MAX);
        repeat (4) send_pair(SW'(70000), SW'(-70000), 1'b0);
        repeat (4) send_pair(SW'(-8388608), SW'(8388607), 1'b0);

        // left fully open, right fully closed, ahead of the long-hold run
        settle();
        configure(THRESH_MAX, 0, 0, 0);
        send_pair(SW'(-8388608), SW'(0), 1'b0);

        // near-maximum hold: counts keep climbing but never pass it, gains stay put
        settle();
        configure(THRESH_MAX, 65534, 32768, 32768);
        for (int n = 0; n < SAT_ITEMS; n++)
            send_pair(SW'(8388000), SW'(-8388608), n == SAT_ITEMS - 1);

        // random phases over several register settings
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            settle();
            case (ph)
                0: configure($urandom_range(0, 300000), $urandom_range(0, 8),
                             $urandom_range(0, REG16_MAX), $urandom_range(0, REG16_MAX));
                1: configure(0, 0, REG16_MAX, 0);
                2: configure(THRESH_MAX, REG16_MAX, REG16_MAX, REG16_MAX);
                3: configure($urandom_range(1, THRESH_MAX), $urandom_range(0, 30),
                             $urandom_range(60000, REG16_MAX), $urandom_range(60000, REG16_MAX));
                default: configure($urandom_range(0, 300000), $urandom_range(0, 16),
                                   $urandom_range(0, REG16_MAX), $urandom_range(0, REG16_MAX));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // idle bursts with calm windows, none in the final phase
                idle_on = (ph < RAND_PHASES - 1) && ((n / 100) % 3 != 2);
                if (ph == 0 && n == 100)
                    hold_off_req++;
                if (ph == 0 && n == 250)
                    settle();
                send_pair(next_sample(0), next_sample(1), $urandom_range(0, 7) == 0);
            end
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/snh_pkg.sv
rtl/core/snh_mul.sv
rtl/core/stereo_noise_gate_hold.sv
rtl/core/snh_checker.sv
verif/snh_checker.sv
verif/tb_top.sv
